/* rtl/core/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg
// shared types and constants of the hierarchical timer wheel
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int SLOTS_PER_LEVEL_DEF = 4;
  localparam int LEVELS_DEF          = 3;
  localparam int TIMERS_DEF          = 16;

  localparam int OP_W   = 1;
  localparam int ID_W   = 4;
  localparam int DLY_W  = 6;
  localparam int KIND_W = 3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [KIND_W-1:0] EV_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] EV_ZERO     = 3'd1;
  localparam logic [KIND_W-1:0] EV_RANGE    = 3'd2;
  localparam logic [KIND_W-1:0] EV_BUSY     = 3'd3;
  localparam logic [KIND_W-1:0] EV_EXPIRED  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_TAKE,
    ST_WALK,
    ST_VISIT,
    ST_LAST
  } htw_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch input beat
    logic do_start;   // evaluate start and emit its result
    logic advance;    // step cursor of current level, detach slot
    logic walk;       // handle one timer of detached list
    logic next_level; // move to next level
    logic finish;     // mark the pending expiry as last
  } htw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic list_empty;  // no timer left in detached list
    logic carry;       // cursor of current level wrapped
    logic top_level;   // current level is the highest
  } htw_status_t;

endpackage

/* rtl/core/htw_datapath.sv */
// ----------------------------------------------------------------------------
// htw_datapath
// wheel state, slot lists and placement arithmetic
// ----------------------------------------------------------------------------
module htw_datapath #(
  parameter int SLOTS_PER_LEVEL = htw_pkg::SLOTS_PER_LEVEL_DEF,
  parameter int LEVELS          = htw_pkg::LEVELS_DEF,
  parameter int TIMERS          = htw_pkg::TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  htw_pkg::htw_cmd_t           cmd,
  output htw_pkg::htw_status_t        stat,
  input  logic [htw_pkg::OP_W-1:0]    op,
  input  logic [htw_pkg::ID_W-1:0]    timer_id,
  input  logic [htw_pkg::DLY_W-1:0]   delay,
  output logic [htw_pkg::KIND_W-1:0]  event_kind,
  output logic [htw_pkg::ID_W-1:0]    timer_id_res,
  output logic                        last,
  output logic                        strobe
);

  localparam int CW    = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TW    = $clog2(TIMERS + 1);   // holds nil code
  localparam int IW    = $clog2(TIMERS);
  localparam int NSLOT = LEVELS * SLOTS_PER_LEVEL;
  localparam int SW    = $clog2(NSLOT);
  localparam int DW    = htw_pkg::DLY_W;
  localparam logic [TW-1:0] NIL = TW'(TIMERS);
  localparam int MAXD  = SLOTS_PER_LEVEL ** LEVELS;
  localparam logic [CW-1:0] CMAX = CW'(SLOTS_PER_LEVEL - 1);

  logic [CW-1:0] cursor [LEVELS];
  logic [TW-1:0] head   [NSLOT];
  logic [TW-1:0] tail   [NSLOT];
  logic [TW-1:0] link   [TIMERS];
  logic [DW-1:0] remain [TIMERS];
  logic [TIMERS-1:0] active;

  logic [htw_pkg::OP_W-1:0]  op_q;
  logic [htw_pkg::ID_W-1:0]  id_q;
  logic [DW-1:0]             dly_q;
  logic [LW-1:0]             lvl;
  logic [TW-1:0]             walk_t;
  logic                      carry_q;

  // pending expiry held back so last can be set on the final one
  logic                      pend_v;
  logic [htw_pkg::ID_W-1:0]  pend_id;

  // placement: find highest level at or below top with a nonzero offset
  function automatic logic [DW+1:0] span(input int v);
    logic [DW+1:0] s;
    s = 1;
    for (int i = 0; i < LEVELS; i++) if (i < v) s = (DW+2)'(s * SLOTS_PER_LEVEL);
    return s;
  endfunction

  logic [LW-1:0] pl_top;
  logic [DW-1:0] pl_val;
  logic [SW-1:0] pl_slot;
  logic [DW-1:0] pl_rem;

  always_comb begin
    logic found;
    logic [CW-1:0] off;
    logic [DW+1:0] r;
    logic [CW:0] sum;
    found   = 1'b0;
    off     = '0;
    r       = '0;
    sum     = '0;
    pl_slot = '0;
    pl_rem  = '0;
    for (int v = LEVELS - 1; v >= 0; v--) begin
      // quotient by counting whole spans, a level that can take the timer
      // never sees a value of a full turn or more
      off = '0;
      for (int q = 1; q < SLOTS_PER_LEVEL; q++)
        if (32'(pl_val) >= q * int'(span(v))) off = CW'(q);
      if (!found && v <= int'(pl_top) && off != '0) begin
        found = 1'b1;
        r = (DW+2)'(pl_val) - (DW+2)'((DW+2)'(off) * span(v));
        for (int k = 0; k < LEVELS; k++)
          if (k < v) r = (DW+2)'(r + (DW+2)'(cursor[k]) * span(k));
        sum = (CW+1)'(cursor[v]) + (CW+1)'(off);
        if (sum >= (CW+1)'(SLOTS_PER_LEVEL)) sum = sum - (CW+1)'(SLOTS_PER_LEVEL);
        pl_slot = SW'(v * SLOTS_PER_LEVEL) + SW'(sum);
        pl_rem  = DW'(r);
      end
    end
  end

  logic [IW-1:0] wt;
  assign wt = walk_t[IW-1:0];
  logic start_ok;
  logic [htw_pkg::KIND_W-1:0] start_kind;

  always_comb begin
    if (32'(dly_q) >= MAXD || 32'(id_q) >= TIMERS) start_kind = htw_pkg::EV_RANGE;
    else if (dly_q == '0)                          start_kind = htw_pkg::EV_ZERO;
    else if (active[id_q[IW-1:0]])                 start_kind = htw_pkg::EV_BUSY;
    else                                           start_kind = htw_pkg::EV_ACCEPTED;
    start_ok = (start_kind == htw_pkg::EV_ACCEPTED);
    if (cmd.do_start) begin
      pl_top = LW'(LEVELS - 1);
      pl_val = dly_q;
    end else begin
      pl_top = lvl;
      pl_val = remain[wt];
    end
  end

  logic [IW-1:0] pl_id;
  logic          pl_en;
  assign pl_id = cmd.do_start ? id_q[IW-1:0] : wt;
  assign pl_en = (cmd.do_start && start_ok) || (cmd.walk && remain[wt] != '0);

  logic [SW-1:0] cur_slot;
  assign cur_slot = SW'(int'(lvl) * SLOTS_PER_LEVEL) + SW'(cursor[lvl]);

  assign stat.is_tick    = op_q == htw_pkg::OP_TICK;
  assign stat.list_empty = walk_t == NIL;
  assign stat.carry      = carry_q;
  assign stat.top_level  = int'(lvl) == LEVELS - 1;

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      for (int v = 0; v < LEVELS; v++) cursor[v] <= '0;
      for (int s = 0; s < NSLOT; s++) begin
        head[s] <= NIL;
        tail[s] <= NIL;
      end
      active <= '0;
      pend_v <= 1'b0;
      lvl    <= '0;
      walk_t <= NIL;
    end else begin
      if (cmd.load) begin
        op_q   <= op;
        id_q   <= timer_id;
        dly_q  <= delay;
        lvl    <= '0;
        pend_v <= 1'b0;
      end
      if (cmd.do_start) begin
        strobe       <= 1'b1;
        event_kind   <= start_kind;
        timer_id_res <= id_q;
        last         <= 1'b1;
        if (start_ok) active[id_q[IW-1:0]] <= 1'b1;
      end
      if (cmd.advance) begin
        if (cursor[lvl] == CMAX) begin
          cursor[lvl] <= '0;
          carry_q     <= 1'b1;
          walk_t      <= head[SW'(int'(lvl) * SLOTS_PER_LEVEL)];
          head[SW'(int'(lvl) * SLOTS_PER_LEVEL)] <= NIL;
          tail[SW'(int'(lvl) * SLOTS_PER_LEVEL)] <= NIL;
        end else begin
          cursor[lvl] <= cursor[lvl] + 1'b1;
          carry_q     <= 1'b0;
          walk_t      <= head[cur_slot + 1'b1];
          head[cur_slot + 1'b1] <= NIL;
          tail[cur_slot + 1'b1] <= NIL;
        end
      end
      if (cmd.walk) begin
        walk_t <= link[wt];
        if (remain[wt] == '0) begin
          active[wt] <= 1'b0;
          if (pend_v) begin
            strobe       <= 1'b1;
            event_kind   <= htw_pkg::EV_EXPIRED;
            timer_id_res <= pend_id;
            last         <= 1'b0;
          end
          pend_v  <= 1'b1;
          pend_id <= htw_pkg::ID_W'(wt);
        end
      end
      if (pl_en) begin
        link[pl_id]   <= NIL;
        remain[pl_id] <= pl_rem;
        if (head[pl_slot] == NIL) head[pl_slot] <= TW'(pl_id);
        else link[tail[pl_slot][IW-1:0]] <= TW'(pl_id);
        tail[pl_slot] <= TW'(pl_id);
      end
      if (cmd.next_level) lvl <= lvl + 1'b1;
      if (cmd.finish && pend_v) begin
        strobe       <= 1'b1;
        event_kind   <= htw_pkg::EV_EXPIRED;
        timer_id_res <= pend_id;
        last         <= 1'b1;
        pend_v       <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/htw_ctrl.sv */
// ----------------------------------------------------------------------------
// htw_ctrl
// sequencer for start and tick beats
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output htw_pkg::htw_cmd_t     cmd,
  input  htw_pkg::htw_status_t  stat
);

  htw_pkg::htw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= htw_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      htw_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = htw_pkg::ST_ADVANCE;
        end
      end
      htw_pkg::ST_ADVANCE: begin
        if (stat.is_tick) begin
          cmd.advance = 1'b1;
          state_next  = htw_pkg::ST_WALK;
        end else begin
          cmd.do_start = 1'b1;
          state_next   = htw_pkg::ST_IDLE;
        end
      end
      htw_pkg::ST_TAKE: begin
        cmd.advance = 1'b1;
        state_next  = htw_pkg::ST_WALK;
      end
      htw_pkg::ST_WALK: begin
        if (!stat.list_empty) cmd.walk = 1'b1;
        else if (stat.carry && !stat.top_level) begin
          cmd.next_level = 1'b1;
          state_next     = htw_pkg::ST_TAKE;
        end else state_next = htw_pkg::ST_LAST;
      end
      htw_pkg::ST_VISIT: state_next = htw_pkg::ST_LAST;
      htw_pkg::ST_LAST: begin
        cmd.finish = 1'b1;
        state_next = htw_pkg::ST_IDLE;
      end
      default: state_next = htw_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/hierarchical_timer_wheel.sv */
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// three-level timing wheel over a fixed pool of timers
// ----------------------------------------------------------------------------
// One beat at a time; busy is high while a beat is worked on. A start is
// evaluated in ADVANCE and its result is on strobe in the cycle after that
// state. A tick steps the cursor of each visited level (in ADVANCE, then in
// TAKE after each carry into a higher level), walks the detached slot list
// in WALK, one timer a cycle, and ends in LAST; the final expiry is on strobe
// in the cycle in which busy drops. Results appear for one cycle on strobe
// and cannot be held off; a tick on which nothing expires gives no result.
module hierarchical_timer_wheel #(
  parameter int SLOTS_PER_LEVEL = htw_pkg::SLOTS_PER_LEVEL_DEF,
  parameter int LEVELS          = htw_pkg::LEVELS_DEF,
  parameter int TIMERS          = htw_pkg::TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [htw_pkg::OP_W-1:0]    op,
  input  logic [htw_pkg::ID_W-1:0]    timer_id,
  input  logic [htw_pkg::DLY_W-1:0]   delay,
  output logic                        strobe,
  output logic [htw_pkg::KIND_W-1:0]  event_kind,
  output logic [htw_pkg::ID_W-1:0]    timer_id_res,
  output logic                        last
);

  htw_pkg::htw_cmd_t    cmd;
  htw_pkg::htw_status_t stat;

  htw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  htw_datapath #(
    .SLOTS_PER_LEVEL(SLOTS_PER_LEVEL), .LEVELS(LEVELS), .TIMERS(TIMERS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .op(op), .timer_id(timer_id), .delay(delay),
    .event_kind(event_kind), .timer_id_res(timer_id_res),
    .last(last), .strobe(strobe)
  );

endmodule

/* verif/tb_hierarchical_timer_wheel.sv */
// ----------------------------------------------------------------------------
// tb_hierarchical_timer_wheel
// self-checking bench for the hierarchical timer wheel: start and tick beats
// with random gaps, a behavioural model of the wheel predicts every result
// ----------------------------------------------------------------------------
module tb_hierarchical_timer_wheel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = htw_pkg::SLOTS_PER_LEVEL_DEF;
  localparam int NLEV  = htw_pkg::LEVELS_DEF;
  localparam int NTIM  = htw_pkg::TIMERS_DEF;
  localparam int NIL   = NTIM;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDW   = htw_pkg::ID_W;
  localparam int DLW   = htw_pkg::DLY_W;

  typedef struct packed {
    logic [htw_pkg::KIND_W-1:0] kind;
    logic [IDW-1:0]             id;
    logic                       fin;
  } htw_result_t;

  class expiry_scoreboard;
    int cursor[NLEV];
    int head[NLEV][NSLOT];
    int tail[NLEV][NSLOT];
    int link[NTIM];
    int remain[NTIM];
    bit active[NTIM];
    htw_result_t pending[$];
    int errors;

    function new();
      errors = 0;
      foreach (cursor[l]) cursor[l] = 0;
      foreach (head[l, s]) begin
        head[l][s] = NIL;
        tail[l][s] = NIL;
      end
      foreach (active[i]) active[i] = 0;
    endfunction

    function int span(int lv);
      int s;
      s = 1;
      for (int i = 0; i < lv; i++) s *= NSLOT;
      return s;
    endfunction

    function void enqueue(int lv, int slot, int id);
      link[id] = NIL;
      if (head[lv][slot] == NIL) head[lv][slot] = id;
      else link[tail[lv][slot]] = id;
      tail[lv][slot] = id;
    endfunction

    function void place(int id, int value, int top);
      int off;
      int r;
      for (int lv = top; lv >= 0; lv--) begin
        off = value / span(lv);
        if (off > 0) begin
          r = value % span(lv);
          enqueue(lv, (cursor[lv] + off) % NSLOT, id);
          for (int k = lv - 1; k >= 0; k--) r += cursor[k] * span(k);
          remain[id] = r;
          return;
        end
      end
    endfunction

    function void push(logic [htw_pkg::KIND_W-1:0] k, logic [IDW-1:0] id, bit f);
      htw_result_t e;
      e.kind = k;
      e.id = id;
      e.fin = f;
      pending.push_back(e);
    endfunction

    // note an accepted beat and queue the results it causes
    function void note_beat(logic o, logic [IDW-1:0] id, logic [DLW-1:0] dly);
      int t;
      int nx;
      int n;
      bit carry;
      if (o == htw_pkg::OP_START) begin
        if (int'(dly) >= span(NLEV) || int'(id) >= NTIM) push(htw_pkg::EV_RANGE, id, 1);
        else if (dly == '0) push(htw_pkg::EV_ZERO, id, 1);
        else if (active[id]) push(htw_pkg::EV_BUSY, id, 1);
        else begin
          active[id] = 1;
          place(int'(id), int'(dly), NLEV - 1);
          push(htw_pkg::EV_ACCEPTED, id, 1);
        end
        return;
      end
      n = 0;
      for (int lv = 0; lv < NLEV; lv++) begin
        cursor[lv]++;
        carry = cursor[lv] >= NSLOT;
        if (carry) cursor[lv] = 0;
        t = head[lv][cursor[lv]];
        head[lv][cursor[lv]] = NIL;
        tail[lv][cursor[lv]] = NIL;
        while (t != NIL) begin
          nx = link[t];
          if (remain[t] == 0) begin
            active[t] = 0;
            push(htw_pkg::EV_EXPIRED, IDW'(t), 0);
            n++;
          end else place(t, remain[t], lv);
          t = nx;
        end
        if (!carry) break;
      end
      if (n > 0) pending[$].fin = 1;
    endfunction

    function void check(logic [htw_pkg::KIND_W-1:0] k, logic [IDW-1:0] id, logic f);
      htw_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", k, id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $error("event_kind expected %0d actual %0d", e.kind, k); errors++;
      end
      if (id !== e.id) begin
        $error("timer_id_res expected %0d actual %0d", e.id, id); errors++;
      end
      if (f !== e.fin) begin
        $error("last expected %0d actual %0d", e.fin, f); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [htw_pkg::OP_W-1:0] op = '0;
  logic [IDW-1:0] timer_id = '0;
  logic [DLW-1:0] delay = '0;
  logic strobe;
  logic [htw_pkg::KIND_W-1:0] event_kind;
  logic [IDW-1:0] timer_id_res;
  logic last;

  expiry_scoreboard wheel_sb = new();
  int cycles = 0;

  hierarchical_timer_wheel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .timer_id(timer_id), .delay(delay), .strobe(strobe),
    .event_kind(event_kind), .timer_id_res(timer_id_res), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) wheel_sb.note_beat(op, timer_id, delay);
      if (strobe) wheel_sb.check(event_kind, timer_id_res, last);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    return g;
  endfunction

  // drive one beat and hold it until the block takes it; start stays high
  // into the next beat when there is no gap
  task automatic send_beat(logic o, logic [IDW-1:0] id, logic [DLW-1:0] dly);
    int g;
    start <= 1;
    op <= o;
    timer_id <= id;
    delay <= dly;
    do @(posedge clk); while (busy);
    g = gap_len();
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_beat(htw_pkg::OP_TICK, IDW'($urandom), DLW'($urandom));
  endtask

  initial begin
    int pick;
    int wait_cycles;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, rejections, busy timer, same-tick expiries
    send_beat(htw_pkg::OP_START, IDW'(0), DLW'(0));
    send_beat(htw_pkg::OP_START, IDW'(15), DLW'(63));
    send_beat(htw_pkg::OP_START, IDW'(3), DLW'(1));
    send_beat(htw_pkg::OP_START, IDW'(3), DLW'(5));
    send_beat(htw_pkg::OP_START, IDW'(4), DLW'(1));
    send_beat(htw_pkg::OP_START, IDW'(5), DLW'(4));
    send_beat(htw_pkg::OP_START, IDW'(6), DLW'(16));
    send_beat(htw_pkg::OP_START, IDW'(7), DLW'(17));
    send_beat(htw_pkg::OP_START, IDW'(8), DLW'(42));
    send_beat(htw_pkg::OP_START, IDW'(9), DLW'(21));
    send_beat(htw_pkg::OP_START, IDW'(10), DLW'(2));
    send_ticks(2);
    send_beat(htw_pkg::OP_START, IDW'(4), DLW'(3));
    send_ticks(8);
    send_beat(htw_pkg::OP_START, IDW'(0), DLW'(62));
    send_ticks(5);
    // random: mostly valid starts, many ticks to reach cascades
    for (int i = 0; i < 140; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) send_beat(htw_pkg::OP_TICK, IDW'($urandom), DLW'($urandom));
      else if (pick < 8)
        send_beat(htw_pkg::OP_START, IDW'($urandom), DLW'($urandom_range(1, 20)));
      else if (pick < 9)
        send_beat(htw_pkg::OP_START, IDW'($urandom), DLW'($urandom_range(21, 63)));
      else
        send_beat(htw_pkg::OP_START, IDW'($urandom),
                  ($urandom_range(0, 1) != 0) ? DLW'(0) : DLW'($urandom));
    end
    send_ticks(60);
    start <= 0;
    wait_cycles = 0;
    while (wheel_sb.pending.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (wheel_sb.pending.size() != 0) begin
      $error("%0d results never arrived", wheel_sb.pending.size());
      wheel_sb.errors++;
    end
    if (wheel_sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
